// File: sv/m4vt_pkg.sv
// shared widths, mode codes and inter-cell structs for the 4x4 transform unit
`default_nettype none

package m4vt_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 2;
	localparam int SIDE   = 4;

	localparam logic [1:0] MODE_WR_XFORM  = 2'd0;
	localparam logic [1:0] MODE_WR_OPND   = 2'd1;
	localparam logic [1:0] MODE_COMPOSE   = 2'd2;
	localparam logic [1:0] MODE_VECTOR    = 2'd3;

	// one element travelling along the cell chain
	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic                     last;
		logic [IDX_W-1:0]         idx;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] data;
	} hop_t;

	// entry write into one cell's row
	typedef struct packed {
		logic                     en;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] data;
	} wr_t;

	// finished dot product from a cell
	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [IDX_W-1:0] col;
	} stat_t;

endpackage

`default_nettype wire

// File: sv/matrix4_vector_transform_unit.sv
// 4x4 fixed-point matrix unit: entry writes, compose and vector transform
// Input channel: in_valid / in_stall with mode, row, col, entry_value and
// vec_x..vec_w; a transaction is taken when in_valid is high and in_stall low.
// Entry writes (modes 0 and 1) complete in the accepting cycle and give no
// result. Compose (mode 2) and vector transform (mode 3) give one result
// on out_valid / out_stall: out_x..out_w (zero for compose) and overflow.
// A chain of DIM row cells does the work; elements enter cell 0 one per
// cycle and step one cell per cycle. A vector pass feeds DIM elements;
// compose runs DIM such passes back to back, one per operand column.
// After the last pass the sequencer waits for the tail cell to finish its
// dot product. One operation is in flight at a time, and the next is
// taken in the cycle after the result is loaded into the output register.
// in_stall is high while an operation is in flight. A finished result waits
// in the output register while out_stall is high; the next transaction may be
// taken meanwhile, and its result is held back until the register frees.
// Reset clears both matrices to zero and drops out_valid.
`default_nettype none

module matrix4_vector_transform_unit import m4vt_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int DIM       = 4
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire  [1:0]               mode,
	input  wire  [IDX_W-1:0]         row,
	input  wire  [IDX_W-1:0]         col,
	input  wire  signed [DATA_W-1:0] entry_value,
	input  wire  signed [DATA_W-1:0] vec_x,
	input  wire  signed [DATA_W-1:0] vec_y,
	input  wire  signed [DATA_W-1:0] vec_z,
	input  wire  signed [DATA_W-1:0] vec_w,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic signed [DATA_W-1:0] out_w,
	output logic                     overflow
);

	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FEED = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]               state_q;
	logic [1:0]               mode_q;
	logic [IDX_W-1:0]         elem_q;
	logic [IDX_W-1:0]         pass_q;
	logic                     ovf_q;
	logic signed [DATA_W-1:0] op_q [DIM][DIM];
	logic signed [DATA_W-1:0] vec_q [DIM];
	logic signed [DATA_W-1:0] vec_all [SIDE];
	logic signed [DATA_W-1:0] res_out [SIDE];

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_x_q;
	logic signed [DATA_W-1:0] out_y_q;
	logic signed [DATA_W-1:0] out_z_q;
	logic signed [DATA_W-1:0] out_w_q;
	logic                     overflow_q;

	hop_t                     hop [DIM+1];
	stat_t                    stat [DIM];
	logic signed [DATA_W-1:0] res [DIM];
	wr_t                      wr [DIM];

	logic accept;
	logic in_range;
	logic last_elem;
	logic last_pass;
	logic any_ovf;
	logic chain_done;
	logic can_load;
	logic commit;

	assign accept    = in_valid & ~in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign in_range  = ({1'b0, row} < (IDX_W + 1)'(DIM)) && ({1'b0, col} < (IDX_W + 1)'(DIM));
	assign last_elem = elem_q == IDX_W'(DIM - 1);
	assign last_pass = (mode_q != MODE_COMPOSE) || (pass_q == IDX_W'(DIM - 1));
	assign can_load  = ~out_valid_q | ~out_stall;
	assign commit    = (state_q == ST_DONE) && can_load && (mode_q == MODE_COMPOSE);
	assign chain_done = stat[DIM-1].done && (stat[DIM-1].col == pass_q);

	assign vec_all[0] = vec_x;
	assign vec_all[1] = vec_y;
	assign vec_all[2] = vec_z;
	assign vec_all[3] = vec_w;

	always_comb begin
		any_ovf = 1'b0;
		for (int r = 0; r < DIM; r++) any_ovf = any_ovf | (stat[r].done & stat[r].ovf);
	end

	// element feed into the head of the chain
	always_comb begin
		hop[0].valid = state_q == ST_FEED;
		hop[0].first = elem_q == '0;
		hop[0].last  = last_elem;
		hop[0].idx   = elem_q;
		hop[0].col   = pass_q;
		hop[0].data  = (mode_q == MODE_COMPOSE) ? op_q[elem_q[IW-1:0]][pass_q[IW-1:0]]
							: vec_q[elem_q[IW-1:0]];
	end

	genvar g;
	generate
		for (g = 0; g < DIM; g++) begin : g_cell
			assign wr[g].en   = accept && (mode == MODE_WR_XFORM) && in_range &&
							(row == IDX_W'(g));
			assign wr[g].col  = col;
			assign wr[g].data = entry_value;

			m4vt_cell #(
				.FRAC_BITS (FRAC_BITS),
				.DIM       (DIM)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr      (wr[g]),
				.commit  (commit),
				.hop_in  (hop[g]),
				.hop_out (hop[g+1]),
				.stat    (stat[g]),
				.res     (res[g])
			);
		end
		for (g = 0; g < SIDE; g++) begin : g_res
			if (g < DIM) begin : g_live
				assign res_out[g] = res[g];
			end else begin : g_zero
				assign res_out[g] = '0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) op_q[i][j] <= '0;
			end
		end else if (accept && (mode == MODE_WR_OPND) && in_range) begin
			op_q[row[IW-1:0]][col[IW-1:0]] <= entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			for (int i = 0; i < DIM; i++) vec_q[i] <= vec_all[i];
		end
	end

	// sequencer: feed passes, wait for the tail cell, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
			pass_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (state_q != ST_IDLE) ovf_q <= ovf_q | any_ovf;
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_COMPOSE || mode == MODE_VECTOR)) begin
						state_q <= ST_FEED;
						elem_q  <= '0;
						pass_q  <= '0;
						ovf_q   <= 1'b0;
					end
				end
				ST_FEED: begin
					if (last_elem) begin
						elem_q <= '0;
						if (last_pass) begin
							state_q <= ST_WAIT;
						end else begin
							pass_q <= pass_q + 1'b1;
						end
					end else begin
						elem_q <= elem_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (chain_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (can_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && can_load) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && can_load) begin
			out_x_q    <= (mode_q == MODE_VECTOR) ? res_out[0] : '0;
			out_y_q    <= (mode_q == MODE_VECTOR) ? res_out[1] : '0;
			out_z_q    <= (mode_q == MODE_VECTOR) ? res_out[2] : '0;
			out_w_q    <= (mode_q == MODE_VECTOR) ? res_out[3] : '0;
			overflow_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign out_w     = out_w_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire

// File: sv/m4vt_cell.sv
// one row cell: holds a transform row, multiplies the passing element and accumulates
`default_nettype none

module m4vt_cell import m4vt_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int DIM       = 4
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wr_t                      wr,
	input  wire                      commit,
	input  hop_t                     hop_in,
	output hop_t                     hop_out,
	output stat_t                    stat,
	output logic signed [DATA_W-1:0] res
);

	localparam int IW     = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W - 1){1'b0}}};

	logic signed [DATA_W-1:0] row_q [DIM];
	logic signed [DATA_W-1:0] pend_q [DIM];
	hop_t                     ctl_s1;
	logic signed [PROD_W-1:0] mul_s1;
	logic signed [PROD_W-1:0] shifted;
	logic signed [ACC_W-1:0]  trunc_v;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_s2;
	logic [IDX_W-1:0]         col_s2;
	logic                     over_hi;
	logic                     over_lo;
	logic signed [DATA_W-1:0] sat_v;
	stat_t                    stat_q;
	logic signed [DATA_W-1:0] res_q;

	// row storage; compose results land here only once every column is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIM; j++) row_q[j] <= '0;
		end else if (commit) begin
			for (int j = 0; j < DIM; j++) row_q[j] <= pend_q[j];
		end else if (wr.en) begin
			row_q[wr.col[IW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (hop_in.valid) begin
			mul_s1 <= row_q[hop_in.idx[IW-1:0]] * $signed(hop_in.data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= hop_in;
		end
	end

	assign hop_out = ctl_s1;

	// floor towards minus infinity
	assign shifted = mul_s1 >>> FRAC_BITS;
	assign trunc_v = shifted[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= ctl_s1.first ? trunc_v : acc_q + trunc_v;
		end
		col_s2 <= ctl_s1.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= ctl_s1.valid & ctl_s1.last;
		end
	end

	always_comb begin
		over_hi = acc_q > SAT_MAX;
		over_lo = acc_q < SAT_MIN;
		if (over_hi) begin
			sat_v = MAX32;
		end else if (over_lo) begin
			sat_v = MIN32;
		end else begin
			sat_v = acc_q[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else begin
			stat_q.done <= done_s2;
			stat_q.ovf  <= done_s2 & (over_hi | over_lo);
			stat_q.col  <= col_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s2) begin
			res_q                  <= sat_v;
			pend_q[col_s2[IW-1:0]] <= sat_v;
		end
	end

	assign stat = stat_q;
	assign res  = res_q;

endmodule

`default_nettype wire
